>>> src/sbsm_pkg.sv
// ----------------------------------------------------------------------------
// sbsm_pkg: serial bank switch mapper shared definitions
// Beat types, codes, reset values and the size mask helper.
// ----------------------------------------------------------------------------
package sbsm_pkg;

  localparam int OFFSET_BITS = 19;
  localparam int CFG_IDX_W   = 3;
  // program bank bits above the 16 KB page offset
  localparam int PRG_BANK_W  = OFFSET_BITS - 14;

  typedef enum logic [1:0] {
    OP_CPU_RD = 2'd0,
    OP_CPU_WR = 2'd1,
    OP_PPU_RD = 2'd2,
    OP_PPU_WR = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    TGT_NONE      = 3'd0,
    TGT_PRG_ROM   = 3'd1,
    TGT_PRG_RAM   = 3'd2,
    TGT_PRG_NVRAM = 3'd3,
    TGT_CHR_ROM   = 3'd4,
    TGT_CHR_RAM   = 3'd5
  } target_e;

  localparam logic [1:0] RAM_KIND_WORK    = 2'd1;
  localparam logic [1:0] RAM_KIND_BATTERY = 2'd2;
  localparam logic [1:0] CHR_KIND_ROM     = 2'd1;
  localparam logic [1:0] CHR_KIND_RAM     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PRG_ROM_SIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRG_RAM_KIND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRG_RAM_SIZE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHR_KIND     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHR_SIZE     = 3'd4;

  // serial port register select, address bits 14:13
  localparam logic [1:0] SEL_CONTROL  = 2'd0;
  localparam logic [1:0] SEL_CHR_LOW  = 2'd1;
  localparam logic [1:0] SEL_CHR_HIGH = 2'd2;
  localparam logic [1:0] SEL_PRG      = 2'd3;

  localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;
  localparam logic [1:0] PRG_MODE_FIX_LAST  = 2'd3;

  localparam logic [4:0] CONTROL_RESET   = 5'h1C;
  localparam logic [4:0] CONTROL_FIX_SET = 5'h0C;
  localparam logic [2:0] LOAD_BITS       = 3'd5;
  localparam logic [4:0] PRG_LOG_MIN     = 5'd14;
  localparam logic [4:0] PRG_LOG_MAX     = 5'(OFFSET_BITS);

  localparam logic [4:0] CFG_PRG_ROM_SIZE_RST = 5'd15;
  localparam logic [1:0] CFG_PRG_RAM_KIND_RST = 2'd0;
  localparam logic [3:0] CFG_PRG_RAM_SIZE_RST = 4'd13;
  localparam logic [1:0] CFG_CHR_KIND_RST     = 2'd1;
  localparam logic [4:0] CFG_CHR_SIZE_RST     = 5'd13;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] addr;
    logic [7:0]  wr_data;
  } in_item_t;

  typedef struct packed {
    logic [2:0]             target;
    logic [OFFSET_BITS-1:0] offset;
    logic                   write_enable;
    logic [1:0]             mirror;
  } out_item_t;

  typedef struct packed {
    logic [4:0] prg_rom_size_log2;
    logic [1:0] prg_ram_kind;
    logic [3:0] prg_ram_size_log2;
    logic [1:0] chr_kind;
    logic [4:0] chr_size_log2;
  } map_cfg_t;

  typedef struct packed {
    logic [4:0] shift_load;
    logic [2:0] bit_count;
    logic [4:0] control_reg;
    logic [4:0] char_bank_low;
    logic [4:0] char_bank_high;
    logic [4:0] program_bank;
  } map_state_t;

  // ones below bit lg, saturates at the offset width
  function automatic logic [OFFSET_BITS-1:0] size_mask(input logic [4:0] lg);
    logic [OFFSET_BITS-1:0] m;
    for (int i = 0; i < OFFSET_BITS; i++) begin
      m[i] = (32'(lg) > i);
    end
    return m;
  endfunction

endpackage

>>> src/sbsm_xlate.sv
// ----------------------------------------------------------------------------
// sbsm_xlate: access decode and address translation
// Maps one bus access to target, offset and write enable, and works out the
// next serial load and bank register state.
// ----------------------------------------------------------------------------
module sbsm_xlate (
  input  sbsm_pkg::in_item_t   item,
  input  sbsm_pkg::map_cfg_t   cfg,
  input  sbsm_pkg::map_state_t state,
  output sbsm_pkg::out_item_t  result,
  output sbsm_pkg::map_state_t state_next
);
  import sbsm_pkg::*;

  logic [4:0]             prg_lg;
  logic [4:0]             bank_bits;
  logic [PRG_BANK_W-1:0]  win_mask;
  logic [1:0]             prg_mode;
  logic                   upper;
  logic [PRG_BANK_W-1:0]  rom_bank;
  logic [OFFSET_BITS-1:0] prg_off;
  logic [16:0]            chr_raw;
  logic [OFFSET_BITS-1:0] chr_off;
  logic [OFFSET_BITS-1:0] ram_off;
  logic [4:0]             shifted;
  logic [2:0]             count_inc;
  logic                   in_ram_win;

  // program ROM window
  always_comb begin
    if (cfg.prg_rom_size_log2 < PRG_LOG_MIN) begin
      prg_lg = PRG_LOG_MIN;
    end else if (cfg.prg_rom_size_log2 > PRG_LOG_MAX) begin
      prg_lg = PRG_LOG_MAX;
    end else begin
      prg_lg = cfg.prg_rom_size_log2;
    end
    bank_bits = prg_lg - PRG_LOG_MIN;
    for (int i = 0; i < PRG_BANK_W; i++) begin
      win_mask[i] = (32'(bank_bits) > i);
    end
    prg_mode = state.control_reg[3:2];
    upper    = item.addr[15] & item.addr[14];
    case (prg_mode)
      PRG_MODE_FIX_FIRST: rom_bank = upper ? PRG_BANK_W'(state.program_bank) : '0;
      PRG_MODE_FIX_LAST:  rom_bank = upper ? win_mask : PRG_BANK_W'(state.program_bank);
      default:            rom_bank = PRG_BANK_W'({state.program_bank[4:1], upper});
    endcase
    prg_off = {rom_bank & win_mask, item.addr[13:0]};
  end

  // character window
  always_comb begin
    if (!state.control_reg[4]) begin
      chr_raw = {state.char_bank_low[4:1], item.addr[12:0]};
    end else if (!item.addr[12]) begin
      chr_raw = {state.char_bank_low, item.addr[11:0]};
    end else begin
      chr_raw = {state.char_bank_high, item.addr[11:0]};
    end
    chr_off = OFFSET_BITS'(chr_raw) & size_mask(cfg.chr_size_log2);
    ram_off = OFFSET_BITS'(item.addr[12:0]) & size_mask({1'b0, cfg.prg_ram_size_log2});
  end

  assign in_ram_win = (item.addr[15:13] == 3'b011);

  always_comb begin
    result.target       = TGT_NONE;
    result.offset       = '0;
    result.write_enable = 1'b0;
    case (item.op)
      OP_CPU_RD, OP_CPU_WR: begin
        if (in_ram_win) begin
          if (cfg.prg_ram_kind inside {RAM_KIND_WORK, RAM_KIND_BATTERY}) begin
            result.target       = (cfg.prg_ram_kind == RAM_KIND_WORK) ?
                                  TGT_PRG_RAM : TGT_PRG_NVRAM;
            result.offset       = ram_off;
            result.write_enable = (item.op == OP_CPU_WR);
          end
        end else if (item.addr[15] && item.op == OP_CPU_RD) begin
          result.target = TGT_PRG_ROM;
          result.offset = prg_off;
        end
      end
      default: begin
        if (item.addr[15:13] == 3'b000) begin
          if (item.op == OP_PPU_RD && cfg.chr_kind == CHR_KIND_ROM) begin
            result.target = TGT_CHR_ROM;
            result.offset = chr_off;
          end else if (cfg.chr_kind == CHR_KIND_RAM) begin
            result.target       = TGT_CHR_RAM;
            result.offset       = chr_off;
            result.write_enable = (item.op == OP_PPU_WR);
          end
        end
      end
    endcase
    result.mirror = state_next.control_reg[1:0];
  end

  // serial register port
  assign shifted   = {item.wr_data[0], state.shift_load[4:1]};
  assign count_inc = state.bit_count + 3'd1;

  always_comb begin
    state_next = state;
    if (item.op == OP_CPU_WR && item.addr[15]) begin
      if (item.wr_data[7]) begin
        state_next.shift_load  = '0;
        state_next.bit_count   = '0;
        state_next.control_reg = state.control_reg | CONTROL_FIX_SET;
      end else if (count_inc == LOAD_BITS) begin
        state_next.shift_load = '0;
        state_next.bit_count  = '0;
        case (item.addr[14:13])
          SEL_CONTROL:  state_next.control_reg    = shifted;
          SEL_CHR_LOW:  state_next.char_bank_low  = shifted;
          SEL_CHR_HIGH: state_next.char_bank_high = shifted;
          SEL_PRG:      state_next.program_bank   = shifted;
          default:      state_next.program_bank   = shifted;
        endcase
      end else begin
        state_next.shift_load = shifted;
        state_next.bit_count  = count_inc;
      end
    end
  end

endmodule

>>> src/serial_bank_switch_mapper_core.sv
// ----------------------------------------------------------------------------
// serial_bank_switch_mapper_core: serial bank switch memory mapper
// Translates CPU and PPU bus accesses to memory targets and offsets.
// ----------------------------------------------------------------------------
// Usage:
//   in:  one beat per bus access (op, addr, wr_data), valid/ready.
//   out: one beat per access (target, offset, write_enable, mirror).
//   cfg: register index and data, always ready; write only while idle.
// A beat accepted at an edge is written to the output register, or to the
// skid stage while out is stalled. Throughput is one beat per cycle while
// in_ready is high, set by the single decode pass that updates the mapper
// registers as the beat is accepted. The output register is backed by a
// one-beat skid stage, so a stalled receiver holds one more beat before
// in_ready drops; in_ready depends only on registered state.
// Reset clears both stages and loads the control register with fixed-last
// program mode, all banks zero, and the default memory configuration.
// ----------------------------------------------------------------------------
module serial_bank_switch_mapper_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  sbsm_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output sbsm_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sbsm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [7:0]                          cfg_data
);
  import sbsm_pkg::*;

  map_cfg_t   cfg;
  map_state_t state;
  map_state_t state_next;
  out_item_t  result;
  out_item_t  skid;
  logic       skid_valid;
  logic       accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid;
  assign accept    = in_valid && in_ready;

  sbsm_xlate u_xlate (
    .item       (in_data),
    .cfg        (cfg),
    .state      (state),
    .result     (result),
    .state_next (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prg_rom_size_log2 <= CFG_PRG_ROM_SIZE_RST;
      cfg.prg_ram_kind      <= CFG_PRG_RAM_KIND_RST;
      cfg.prg_ram_size_log2 <= CFG_PRG_RAM_SIZE_RST;
      cfg.chr_kind          <= CFG_CHR_KIND_RST;
      cfg.chr_size_log2     <= CFG_CHR_SIZE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PRG_ROM_SIZE: cfg.prg_rom_size_log2 <= cfg_data[4:0];
        REG_PRG_RAM_KIND: cfg.prg_ram_kind      <= cfg_data[1:0];
        REG_PRG_RAM_SIZE: cfg.prg_ram_size_log2 <= cfg_data[3:0];
        REG_CHR_KIND:     cfg.chr_kind          <= cfg_data[1:0];
        REG_CHR_SIZE:     cfg.chr_size_log2     <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.shift_load     <= '0;
      state.bit_count      <= '0;
      state.control_reg    <= CONTROL_RESET;
      state.char_bank_low  <= '0;
      state.char_bank_high <= '0;
      state.program_bank   <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_data <= skid;
      end else if (accept) begin
        out_data <= result;
      end
    end else if (accept) begin
      skid <= result;
    end
  end

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a beat while output is empty");

  a_stall_to_skid: assert property (@(posedge clk) disable iff (rst)
    (accept && out_valid && !out_ready) |=> skid_valid)
    else $error("beat accepted under stall was not captured");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    state.bit_count < LOAD_BITS)
    else $error("serial bit count out of range");

  a_none_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.target == TGT_NONE) |->
      (out_data.offset == '0 && !out_data.write_enable))
    else $error("unmapped beat carries offset or write enable");
`endif

endmodule
